// ===== rtl/c3f_pkg.sv =====
// Shared types and constants of the 3x3 clamped convolution filter.
`timescale 1ns / 1ps

package c3f_pkg;

  localparam int PIX_W   = 8;
  localparam int COORD_W = 10;
  localparam int DIM_W   = 11;
  localparam int KROW_W  = 24;
  localparam int CFG_W   = 24;
  localparam int IDX_W   = 3;
  localparam int PROD_W  = 17;
  localparam int RSUM_W  = 19;
  localparam int SUM_W   = 21;

  // configuration register indexes
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH       = 3'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT      = 3'd1;
  localparam logic [IDX_W-1:0] REG_KERNEL_ROW_TOP    = 3'd2;
  localparam logic [IDX_W-1:0] REG_KERNEL_ROW_MIDDLE = 3'd3;
  localparam logic [IDX_W-1:0] REG_KERNEL_ROW_BOTTOM = 3'd4;

  localparam logic [DIM_W-1:0]  DIM_RESET  = 11'd1024;
  localparam logic [DIM_W-1:0]  DIM_MIN    = 11'd3;
  localparam logic [KROW_W-1:0] KROW_RESET = 24'hFF0001;
  localparam logic [SUM_W-1:0]  PIX_MAX    = 21'd255;

  typedef logic [PIX_W-1:0]          pix_t;
  typedef logic [COORD_W-1:0]        coord_t;
  typedef logic signed [PIX_W-1:0]   coef_t;
  typedef pix_t  [2:0][2:0]          nbhd_t;    // [row][col], row 0 top, col 0 left
  typedef coef_t [2:0][2:0]          kernel_t;  // same layout as nbhd_t

  // position data that travels with one pixel through the pipeline
  typedef struct packed {
    logic   interior;
    coord_t column;
    coord_t row;
    logic   frame_end;
  } meta_t;

endpackage

// ===== rtl/c3f_if.sv =====
// Valid/ready stream interfaces for input pixels and filtered results.
`timescale 1ns / 1ps

interface c3f_pix_if;
  logic          valid;
  logic          ready;
  c3f_pkg::pix_t pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

interface c3f_res_if;
  logic            valid;
  logic            ready;
  c3f_pkg::pix_t   pixel_out;
  c3f_pkg::coord_t out_column;
  c3f_pkg::coord_t out_row;
  logic            frame_end;

  modport source (output valid, output pixel_out, output out_column, output out_row,
                  output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input out_column, input out_row,
                  input frame_end, output ready);
endinterface

// ===== rtl/c3f_window.sv =====
// Line buffer memories and 3x3 window: read at accept, write back in the cycle after.
`timescale 1ns / 1ps

module c3f_window #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  input  c3f_pkg::pix_t             req_pixel,
  input  logic [$clog2(MAX_WIDTH)-1:0] req_col,
  input  c3f_pkg::meta_t            req_meta,
  output logic                      req_ready,
  output logic                      nb_valid,
  output c3f_pkg::nbhd_t            nb,
  output c3f_pkg::meta_t            nb_meta,
  input  logic                      nb_ready
);

  localparam int AW = $clog2(MAX_WIDTH);

  c3f_pkg::pix_t line_above [MAX_WIDTH];
  c3f_pkg::pix_t line_two_above [MAX_WIDTH];

  c3f_pkg::pix_t              rd_above;
  c3f_pkg::pix_t              rd_two_above;
  logic                       s1_valid;
  c3f_pkg::pix_t              s1_pixel;
  logic [AW-1:0]              s1_col;
  c3f_pkg::meta_t             s1_meta;
  c3f_pkg::pix_t [2:0][1:0]   win;
  logic                       s1_leave;

  // border pixels leave without waiting for the multiply pipeline
  assign s1_leave  = s1_valid && (!s1_meta.interior || nb_ready);
  assign req_ready = !s1_valid || s1_leave;
  assign nb_valid  = s1_valid && s1_meta.interior;
  assign nb_meta   = s1_meta;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nb[r][0] = win[r][0];
      nb[r][1] = win[r][1];
    end
    nb[0][2] = rd_two_above;
    nb[1][2] = rd_above;
    nb[2][2] = s1_pixel;
  end

  // read port: one registered read per accepted pixel
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      rd_above     <= line_above[req_col];
      rd_two_above <= line_two_above[req_col];
      s1_pixel     <= req_pixel;
      s1_col       <= req_col;
      s1_meta      <= req_meta;
    end
  end

  // write-back repeats while stalled with the same data; the next read
  // always targets another column, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (s1_valid) begin
      line_two_above[s1_col] <= rd_above;
      line_above[s1_col]     <= s1_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      win      <= '0;
    end else begin
      if (req_ready) begin
        s1_valid <= req_valid;
      end
      if (s1_leave) begin
        for (int r = 0; r < 3; r++) begin
          win[r][0] <= nb[r][1];
          win[r][1] <= nb[r][2];
        end
      end
    end
  end

endmodule

// ===== rtl/c3f_mac.sv =====
// Nine multiplies, row sums, final sum and clamp to 0..255, with output register.
`timescale 1ns / 1ps

module c3f_mac (
  input  logic             clk,
  input  logic             rst,
  input  logic             nb_valid,
  input  c3f_pkg::nbhd_t   nb,
  input  c3f_pkg::meta_t   nb_meta,
  output logic             nb_ready,
  input  c3f_pkg::kernel_t kernel,
  c3f_res_if.source        res
);

  logic                                    v2, v3, v4, vo;
  logic                                    ld2, ld3, ld4, ldo;
  c3f_pkg::nbhd_t                          nb2;
  c3f_pkg::meta_t                          m2, m3, m4;
  logic signed [c3f_pkg::PROD_W-1:0]       prod [3][3];
  logic signed [c3f_pkg::RSUM_W-1:0]       rsum [3];
  logic signed [c3f_pkg::SUM_W-1:0]        total;
  c3f_pkg::pix_t                           clamped;

  assign ldo      = !vo || res.ready;
  assign ld4      = !v4 || ldo;
  assign ld3      = !v3 || ld4;
  assign ld2      = !v2 || ld3;
  assign nb_ready = ld2;
  assign res.valid = vo;

  always_comb begin
    total = {{2{rsum[0][c3f_pkg::RSUM_W-1]}}, rsum[0]}
          + {{2{rsum[1][c3f_pkg::RSUM_W-1]}}, rsum[1]}
          + {{2{rsum[2][c3f_pkg::RSUM_W-1]}}, rsum[2]};
    if (total[c3f_pkg::SUM_W-1]) begin
      clamped = '0;
    end else if (total > $signed(c3f_pkg::PIX_MAX)) begin
      clamped = '1;
    end else begin
      clamped = total[c3f_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      nb2 <= nb;
      m2  <= nb_meta;
    end
    if (ld3) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod[r][c] <= $signed({1'b0, nb2[r][c]}) * $signed(kernel[r][c]);
        end
      end
      m3 <= m2;
    end
    if (ld4) begin
      for (int r = 0; r < 3; r++) begin
        rsum[r] <= {{2{prod[r][0][c3f_pkg::PROD_W-1]}}, prod[r][0]}
                 + {{2{prod[r][1][c3f_pkg::PROD_W-1]}}, prod[r][1]}
                 + {{2{prod[r][2][c3f_pkg::PROD_W-1]}}, prod[r][2]};
      end
      m4 <= m3;
    end
    if (ldo) begin
      res.pixel_out  <= clamped;
      res.out_column <= m4.column;
      res.out_row    <= m4.row;
      res.frame_end  <= m4.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      vo <= 1'b0;
    end else begin
      if (ld2) v2 <= nb_valid;
      if (ld3) v3 <= v2;
      if (ld4) v4 <= v3;
      if (ldo) vo <= v4;
    end
  end

endmodule

// ===== rtl/conv3x3_clamped_filter_top.sv =====
// Top level of the 3x3 clamped convolution filter: configuration, position counters.
`timescale 1ns / 1ps

// 3x3 convolution over an 8-bit raster pixel stream, one pixel per clock sustained
// while the output is not stalled. Each accepted pixel reads its column from two
// line buffer memories (one registered read port each) and writes the column back
// in the next cycle, which is what sets the rate at one pixel per clock. For each
// interior pixel the filtered value passes the window, neighbourhood, product,
// row sum and output registers; no result is produced for positions in the first
// and last rows and columns. Frame width and height are clamped to 3..MAX_WIDTH and
// 3..MAX_HEIGHT. The line buffers need no clearing after reset: an entry is read
// before it is written only in the first two rows of a frame, and those reads
// reach border pixels alone.
// Configuration may be written only while no pixel is in flight.
module conv3x3_clamped_filter_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [c3f_pkg::IDX_W-1:0]     cfg_index,
  input  logic [c3f_pkg::CFG_W-1:0]     cfg_data,
  c3f_pix_if.sink                       in_stream,
  c3f_res_if.source                     out_stream
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  logic [c3f_pkg::DIM_W-1:0]  image_width;
  logic [c3f_pkg::DIM_W-1:0]  image_height;
  logic [c3f_pkg::KROW_W-1:0] kernel_row [3];
  c3f_pkg::kernel_t           kernel;

  logic [CW-1:0]  column_count;
  logic [RW-1:0]  row_count;
  logic [CW-1:0]  w_last;
  logic [RW-1:0]  h_last;
  logic [CW-1:0]  col;
  logic [RW-1:0]  row;
  logic           row_last;
  logic           frame_last;
  logic           accept;
  c3f_pkg::meta_t meta;

  logic           nb_valid;
  logic           nb_ready;
  c3f_pkg::nbhd_t nb;
  c3f_pkg::meta_t nb_meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= c3f_pkg::DIM_RESET;
      image_height  <= c3f_pkg::DIM_RESET;
      kernel_row[0] <= c3f_pkg::KROW_RESET;
      kernel_row[1] <= c3f_pkg::KROW_RESET;
      kernel_row[2] <= c3f_pkg::KROW_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        c3f_pkg::REG_IMAGE_WIDTH:       image_width   <= cfg_data[c3f_pkg::DIM_W-1:0];
        c3f_pkg::REG_IMAGE_HEIGHT:      image_height  <= cfg_data[c3f_pkg::DIM_W-1:0];
        c3f_pkg::REG_KERNEL_ROW_TOP:    kernel_row[0] <= cfg_data;
        c3f_pkg::REG_KERNEL_ROW_MIDDLE: kernel_row[1] <= cfg_data;
        c3f_pkg::REG_KERNEL_ROW_BOTTOM: kernel_row[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        kernel[r][c] = kernel_row[r][8*c +: 8];
      end
    end
  end

  // last column and row in use, after clamping the configured size
  always_comb begin
    if (image_width < c3f_pkg::DIM_MIN) begin
      w_last = CW'(2);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(image_width - 11'd1);
    end
    if (image_height < c3f_pkg::DIM_MIN) begin
      h_last = RW'(2);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_last = RW'(MAX_HEIGHT - 1);
    end else begin
      h_last = RW'(image_height - 11'd1);
    end
  end

  // a counter left past a smaller new size acts as the last position
  assign col        = (column_count > w_last) ? w_last : column_count;
  assign row        = (row_count > h_last) ? h_last : row_count;
  assign row_last   = (col == w_last);
  assign frame_last = row_last && (row == h_last);
  assign accept     = in_stream.valid && in_stream.ready;

  always_comb begin
    meta.interior  = (col >= CW'(2)) && (row >= RW'(2));
    meta.column    = c3f_pkg::coord_t'(col - CW'(1));
    meta.row       = c3f_pkg::coord_t'(row - RW'(1));
    meta.frame_end = frame_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (row_last) begin
        column_count <= '0;
        row_count    <= frame_last ? '0 : row + RW'(1);
      end else begin
        column_count <= col + CW'(1);
        row_count    <= row;
      end
    end
  end

  c3f_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .req_valid (in_stream.valid),
    .req_pixel (in_stream.pixel_in),
    .req_col   (col),
    .req_meta  (meta),
    .req_ready (in_stream.ready),
    .nb_valid  (nb_valid),
    .nb        (nb),
    .nb_meta   (nb_meta),
    .nb_ready  (nb_ready)
  );

  c3f_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .nb_valid (nb_valid),
    .nb       (nb),
    .nb_meta  (nb_meta),
    .nb_ready (nb_ready),
    .kernel   (kernel),
    .res      (out_stream)
  );

endmodule
